// ----- rtl/tsf_pkg.sv -----
`default_nettype none
package tsf_pkg;
	localparam int unsigned MAX_PAYLOAD_DEFAULT = 65536;
	localparam int unsigned HDR_BYTES = 8;
	localparam int unsigned WORD_BYTES = 4;
	localparam logic [31:0] FLAG_MASK_RESET = 32'h2000_0000;
endpackage
`default_nettype wire

// ----- rtl/tlv_stream_finder.sv -----
// out_valid is set as the input stage advances with the last item of a payload
// throughput: one payload item per cycle, set by the walk update between the
// input stage and result registers; a last item stalls while a result is held
// reset: arst_n clears the walk state, the stage and result valids, and
// loads the compression flag mask with 0x20000000
`default_nettype none
module tlv_stream_finder #(
	parameter int unsigned MAX_PAYLOAD_BYTES = tsf_pkg::MAX_PAYLOAD_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  payload_byte,
	input  wire logic        last_byte,
	input  wire logic [31:0] wanted_type,
	input  wire logic [12:0] wanted_index,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             status,
	output logic [31:0]      raw_type,
	output logic [15:0]      value_length,
	output logic [15:0]      value_offset,
	output logic [31:0]      first_word,
	output logic             nul_terminated
);
	import tsf_pkg::*;

	localparam int unsigned POS_W = $clog2(MAX_PAYLOAD_BYTES + 1);
	localparam int unsigned START_W = $clog2(MAX_PAYLOAD_BYTES);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_SKIP,
		PH_VALUE,
		PH_STOP
	} phase_t;

	logic [31:0] mask_q;

	// input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic [31:0] wtype_s1;
	logic [12:0] widx_s1;

	// walk state
	logic [POS_W-1:0]   pos_q;
	logic [START_W-1:0] start_q;
	logic [63:0]        hs_q;
	logic [31:0]        left_q;
	phase_t             phase_q;
	logic [12:0]        mcnt_q;
	logic [31:0]        htype_q;
	logic [12:0]        hidx_q;
	logic               found_q;
	logic [31:0]        flen_q;
	logic [31:0]        word_q;
	logic [2:0]         vcnt_q;
	logic [7:0]         lastb_q;

	logic [POS_W-1:0]   n_pos;
	logic [START_W-1:0] n_start;
	logic [63:0]        n_hs;
	logic [31:0]        n_left;
	phase_t             n_phase;
	logic [12:0]        n_mcnt;
	logic [31:0]        n_htype;
	logic [12:0]        n_hidx;
	logic               n_found;
	logic [31:0]        n_flen;
	logic [31:0]        n_word;
	logic [2:0]         n_vcnt;
	logic [7:0]         n_lastb;

	logic [63:0] hs_shift;
	logic [31:0] hdr_len;
	logic [31:0] hdr_type;
	logic [31:0] eff_type;
	logic [31:0] body_len;
	logic [31:0] off_sum;

	logic advance_s1;

	assign cfg_ready = 1'b1;
	assign advance_s1 = valid_s1 && (!last_s1 || !out_valid || out_ready);
	assign in_ready = !valid_s1 || advance_s1;

	assign hs_shift = {hs_q[55:0], byte_s1};
	assign hdr_len = hs_shift[63:32];
	assign hdr_type = hs_shift[31:0];
	assign eff_type = ((hdr_type & mask_q) == mask_q) ? (hdr_type ^ mask_q) : hdr_type;
	assign body_len = hdr_len - 32'(HDR_BYTES);

	always_comb begin
		n_pos = pos_q;
		n_start = start_q;
		n_hs = hs_q;
		n_left = left_q;
		n_phase = phase_q;
		n_mcnt = mcnt_q;
		n_htype = (pos_q == '0) ? wtype_s1 : htype_q;
		n_hidx = (pos_q == '0) ? widx_s1 : hidx_q;
		n_found = found_q;
		n_flen = flen_q;
		n_word = word_q;
		n_vcnt = vcnt_q;
		n_lastb = lastb_q;
		if (pos_q >= POS_W'(MAX_PAYLOAD_BYTES)) begin
			n_phase = PH_STOP;
			n_found = 1'b0;
		end else begin
			n_pos = pos_q + 1'b1;
			case (phase_q)
				PH_HEADER: begin
					if (left_q == '0) begin
						n_start = pos_q[START_W-1:0];
					end
					n_hs = hs_shift;
					n_left = left_q + 32'd1;
					if (left_q == 32'(HDR_BYTES - 1)) begin
						n_left = '0;
						if (hdr_len < 32'(HDR_BYTES)) begin
							n_phase = PH_STOP;
						end else if (n_htype != '0 && eff_type != n_htype) begin
							n_left = body_len;
							n_phase = (body_len == '0) ? PH_HEADER : PH_SKIP;
						end else if (mcnt_q != n_hidx) begin
							n_mcnt = mcnt_q + 13'd1;
							n_left = body_len;
							n_phase = (body_len == '0) ? PH_HEADER : PH_SKIP;
						end else begin
							n_flen = body_len;
							n_word = '0;
							n_vcnt = '0;
							n_lastb = '0;
							n_left = body_len;
							if (body_len == '0) begin
								n_found = 1'b1;
								n_phase = PH_STOP;
							end else begin
								n_phase = PH_VALUE;
							end
						end
					end
				end
				PH_SKIP: begin
					n_left = left_q - 32'd1;
					if (left_q == 32'd1) begin
						n_phase = PH_HEADER;
					end
				end
				PH_VALUE: begin
					if (vcnt_q < 3'(WORD_BYTES)) begin
						n_word = {word_q[23:0], byte_s1};
						n_vcnt = vcnt_q + 3'd1;
					end
					n_lastb = byte_s1;
					n_left = left_q - 32'd1;
					if (left_q == 32'd1) begin
						n_found = 1'b1;
						n_phase = PH_STOP;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign off_sum = {{(32 - START_W){1'b0}}, n_start} + 32'(HDR_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= FLAG_MASK_RESET;
			valid_s1 <= 1'b0;
			out_valid <= 1'b0;
			pos_q <= '0;
			start_q <= '0;
			hs_q <= '0;
			left_q <= '0;
			phase_q <= PH_HEADER;
			mcnt_q <= '0;
			htype_q <= '0;
			hidx_q <= '0;
			found_q <= 1'b0;
			flen_q <= '0;
			word_q <= '0;
			vcnt_q <= '0;
			lastb_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mask_q <= cfg_data;
			end
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance_s1) begin
				valid_s1 <= 1'b0;
			end
			if (advance_s1 && last_s1) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (advance_s1) begin
				if (last_s1) begin
					pos_q <= '0;
					start_q <= '0;
					hs_q <= '0;
					left_q <= '0;
					phase_q <= PH_HEADER;
					mcnt_q <= '0;
					htype_q <= '0;
					hidx_q <= '0;
					found_q <= 1'b0;
					flen_q <= '0;
					word_q <= '0;
					vcnt_q <= '0;
					lastb_q <= '0;
				end else begin
					pos_q <= n_pos;
					start_q <= n_start;
					hs_q <= n_hs;
					left_q <= n_left;
					phase_q <= n_phase;
					mcnt_q <= n_mcnt;
					htype_q <= n_htype;
					hidx_q <= n_hidx;
					found_q <= n_found;
					flen_q <= n_flen;
					word_q <= n_word;
					vcnt_q <= n_vcnt;
					lastb_q <= n_lastb;
				end
			end
		end
	end

	// stage and result payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= payload_byte;
			last_s1 <= last_byte;
			wtype_s1 <= wanted_type;
			widx_s1 <= wanted_index;
		end
		if (advance_s1 && last_s1) begin
			status <= !n_found;
			raw_type <= n_found ? n_hs[31:0] : '0;
			value_length <= n_found ? n_flen[15:0] : '0;
			value_offset <= n_found ? off_sum[15:0] : '0;
			first_word <= (n_found && n_flen >= 32'(WORD_BYTES)) ? n_word : '0;
			nul_terminated <= n_found && (n_flen == '0 || n_lastb == '0);
		end
	end

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> raw_type == '0 && value_length == '0 &&
			value_offset == '0 && first_word == '0 && !nul_terminated)
		else $error("not found item carries nonzero fields");

	a_found_stops: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> phase_q == PH_STOP)
		else $error("match found while walk still running");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && last_s1 && out_valid && !out_ready)
		else $error("input stalled without a held result");

	a_word_count: assert property (@(posedge clk) disable iff (!arst_n)
		vcnt_q <= 3'(WORD_BYTES))
		else $error("value byte count past word size");
endmodule
`default_nettype wire

// ----- tb/tb_tlv_stream_finder.sv -----
`default_nettype none
module tb_tlv_stream_finder;

	localparam logic STATUS_FOUND = 1'b0;
	localparam logic STATUS_MISSING = 1'b1;
	localparam int IDLE_LIMIT = 1000;
	localparam int PHASE_BYTES = 140;

	typedef enum logic [1:0] {WALK_HEADER, WALK_SKIP, WALK_VALUE, WALK_STOP} walk_e;

	typedef struct {
		logic [7:0]  data;
		logic        last;
		logic [31:0] wanted_type;
		logic [12:0] wanted_index;
	} byte_item_t;

	typedef struct {
		logic        status;
		logic [31:0] raw_type;
		logic [15:0] value_length;
		logic [15:0] value_offset;
		logic [31:0] first_word;
		logic        nul;
	} tlv_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic [7:0]  payload_byte = '0;
	logic        last_byte = 1'b0;
	logic [31:0] wanted_type = '0;
	logic [12:0] wanted_index = '0;
	logic        out_ready = 1'b0;
	logic        cfg_ready;
	logic        in_ready;
	logic        out_valid;
	logic        status;
	logic [31:0] raw_type;
	logic [15:0] value_length;
	logic [15:0] value_offset;
	logic [31:0] first_word;
	logic        nul_terminated;

	tlv_stream_finder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.payload_byte(payload_byte),
		.last_byte(last_byte),
		.wanted_type(wanted_type),
		.wanted_index(wanted_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.raw_type(raw_type),
		.value_length(value_length),
		.value_offset(value_offset),
		.first_word(first_word),
		.nul_terminated(nul_terminated)
	);

	always #5 clk = ~clk;

	// stimulus and expected results
	byte_item_t  pending[$];
	tlv_result_t results_due[$];
	logic [7:0]  frame[$];
	byte_item_t  cur_item;
	int          send_gap = 0;
	int          hold_cnt = 0;
	int          calm[2] = '{0, 0};
	int          errors = 0;
	int          bytes_sent = 0;
	int          payloads = 0;
	int          mask_settings = 1;
	int          found_seen = 0;
	int          missing_seen = 0;
	int          idle_cycles = 0;

	// walk state of the predictor
	logic [31:0] mask_model = tsf_pkg::FLAG_MASK_RESET;
	logic [16:0] pos = '0;
	logic [15:0] tlv_base = '0;
	logic [63:0] hdr = '0;
	logic [31:0] remaining = '0;
	walk_e       phase = WALK_HEADER;
	logic [12:0] seen = '0;
	logic [31:0] want_type = '0;
	logic [12:0] want_idx = '0;
	logic        hit = 1'b0;
	logic [31:0] hit_len = '0;
	logic [31:0] word_acc = '0;
	logic [7:0]  tail_byte = '0;

	function automatic int draw_wait(input int side);
		if (calm[side] > 0) begin
			calm[side]--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0)
			calm[side] = $urandom_range(10, 40);
		return $urandom_range(0, 6);
	endfunction

	function automatic void walk_byte(input byte_item_t it);
		logic [16:0] p;
		logic [31:0] hlen;
		logic [31:0] eff;
		logic        other;
		tlv_result_t r;
		if (pos == 0) begin
			want_type = it.wanted_type;
			want_idx = it.wanted_index;
		end
		p = pos;
		if (p >= 17'(tsf_pkg::MAX_PAYLOAD_DEFAULT)) begin
			phase = WALK_STOP;
			hit = 1'b0;
		end else begin
			pos = p + 1'b1;
			case (phase)
				WALK_HEADER: begin
					if (remaining == 0)
						tlv_base = p[15:0];
					hdr = {hdr[55:0], it.data};
					remaining = remaining + 1;
					if (remaining >= tsf_pkg::HDR_BYTES) begin
						remaining = 0;
						hlen = hdr[63:32];
						eff = hdr[31:0];
						if (hlen < tsf_pkg::HDR_BYTES) begin
							phase = WALK_STOP;
						end else begin
							if ((eff & mask_model) == mask_model)
								eff = eff ^ mask_model;
							other = (want_type != 0) && (eff != want_type);
							if (other || seen != want_idx) begin
								if (!other)
									seen = seen + 1'b1;
								remaining = hlen - tsf_pkg::HDR_BYTES;
								phase = (remaining == 0) ? WALK_HEADER : WALK_SKIP;
							end else begin
								hit_len = hlen - tsf_pkg::HDR_BYTES;
								word_acc = '0;
								tail_byte = '0;
								remaining = hit_len;
								if (hit_len == 0) begin
									hit = 1'b1;
									phase = WALK_STOP;
								end else begin
									phase = WALK_VALUE;
								end
							end
						end
					end
				end
				WALK_SKIP: begin
					remaining = remaining - 1;
					if (remaining == 0)
						phase = WALK_HEADER;
				end
				WALK_VALUE: begin
					if (hit_len - remaining < tsf_pkg::WORD_BYTES)
						word_acc = {word_acc[23:0], it.data};
					tail_byte = it.data;
					remaining = remaining - 1;
					if (remaining == 0) begin
						hit = 1'b1;
						phase = WALK_STOP;
					end
				end
				default: begin
				end
			endcase
		end
		if (it.last) begin
			r = '{STATUS_MISSING, '0, '0, '0, '0, 1'b0};
			if (hit) begin
				r.status = STATUS_FOUND;
				r.raw_type = hdr[31:0];
				r.value_length = hit_len[15:0];
				r.value_offset = tlv_base + 16'(tsf_pkg::HDR_BYTES);
				r.first_word = (hit_len >= tsf_pkg::WORD_BYTES) ? word_acc : '0;
				r.nul = (hit_len == 0) || (tail_byte == 8'h00);
			end
			results_due.push_back(r);
			pos = '0;
			tlv_base = '0;
			hdr = '0;
			remaining = '0;
			phase = WALK_HEADER;
			seen = '0;
			want_type = '0;
			want_idx = '0;
			hit = 1'b0;
			hit_len = '0;
			word_acc = '0;
			tail_byte = '0;
		end
	endfunction

	function automatic int compare_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v === act_v)
			return 0;
		$display("%0t %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
		return 1;
	endfunction

	function automatic logic [31:0] pick_type();
		case ($urandom_range(0, 7))
			0: return $urandom;
			1, 2, 3: return $urandom_range(1, 3);
			default: return $urandom_range(1, 3) | mask_model;
		endcase
	endfunction

	task automatic put_word(input logic [31:0] w);
		frame.push_back(w[31:24]);
		frame.push_back(w[23:16]);
		frame.push_back(w[15:8]);
		frame.push_back(w[7:0]);
	endtask

	task automatic put_tlv(input logic [31:0] typ, input int vlen);
		put_word(32'(vlen + 8));
		put_word(typ);
		repeat (vlen) frame.push_back(8'($urandom));
		if (vlen > 0 && $urandom_range(0, 2) == 0)
			frame[frame.size() - 1] = 8'h00;
	endtask

	task automatic send_frame(input logic [31:0] wt, input logic [12:0] wi);
		byte_item_t it;
		foreach (frame[i]) begin
			it.data = frame[i];
			it.last = (i == frame.size() - 1);
			it.wanted_type = (i == 0) ? wt : $urandom;
			it.wanted_index = (i == 0) ? wi : 13'($urandom);
			pending.push_back(it);
		end
		bytes_sent += frame.size();
		payloads++;
		frame.delete();
	endtask

	task automatic random_frame();
		int n;
		int vlen;
		int cut;
		logic [31:0] wt;
		logic [12:0] wi;
		n = $urandom_range(1, 5);
		repeat (n) begin
			if ($urandom_range(0, 19) == 0)
				vlen = $urandom_range(13, 48);
			else if ($urandom_range(0, 3) == 0)
				vlen = $urandom_range(0, 3);
			else
				vlen = $urandom_range(4, 12);
			put_tlv(pick_type(), vlen);
		end
		case ($urandom_range(0, 19))
			0: begin
				cut = $urandom_range(1, frame.size());
				while (frame.size() > cut)
					void'(frame.pop_back());
			end
			1: begin
				frame[0] = 8'h00;
				frame[1] = 8'h00;
				frame[2] = 8'h00;
				frame[3] = 8'($urandom_range(0, 7));
			end
			2: begin
				frame.delete();
				repeat ($urandom_range(1, 24)) frame.push_back(8'($urandom));
			end
			3: begin
				put_word($urandom_range(20, 400));
				put_word(pick_type());
				repeat ($urandom_range(0, 10)) frame.push_back(8'($urandom));
			end
			default: begin
			end
		endcase
		case ($urandom_range(0, 7))
			0, 1: wt = '0;
			2: wt = $urandom;
			default: wt = $urandom_range(1, 3);
		endcase
		wi = ($urandom_range(0, 15) == 0) ? 13'($urandom) : 13'($urandom_range(0, 3));
		send_frame(wt, wi);
	endtask

	task automatic drain();
		do @(negedge clk); while (pending.size() != 0 || in_valid || results_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mask(input logic [31:0] v);
		@(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		mask_model = v;
		cfg_valid <= 1'b0;
		mask_settings++;
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				walk_byte(cur_item);
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending.size() != 0) begin
					cur_item = pending.pop_front();
					payload_byte <= cur_item.data;
					last_byte <= cur_item.last;
					wanted_type <= cur_item.wanted_type;
					wanted_index <= cur_item.wanted_index;
					in_valid <= 1'b1;
					send_gap = draw_wait(0);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin : monitor_proc
		tlv_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					$display("%0t result with nothing expected", $time);
					errors++;
				end else begin
					want = results_due.pop_front();
					if (want.status == STATUS_FOUND)
						found_seen++;
					else
						missing_seen++;
					errors += compare_field("status", want.status, status);
					errors += compare_field("raw_type", want.raw_type, raw_type);
					errors += compare_field("value_length", want.value_length, value_length);
					errors += compare_field("value_offset", want.value_offset, value_offset);
					errors += compare_field("first_word", want.first_word, first_word);
					errors += compare_field("nul_terminated", want.nul, nul_terminated);
				end
				hold_cnt = draw_wait(1);
			end else if (hold_cnt > 0) begin
				hold_cnt--;
			end
			out_ready <= (hold_cnt == 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t no handshake for %0d cycles", $time, IDLE_LIMIT);
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int ph;
		int start;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed payloads at the reset mask
		frame.push_back(8'hFF);
		send_frame(32'h0, 13'h0);
		put_word(32'd12);
		put_word(32'h2000_0001);
		put_word(32'hDEAD_BEEF);
		send_frame(32'h1, 13'h0);
		put_word(32'd10);
		put_word(32'h0);
		frame.push_back(8'h41);
		frame.push_back(8'h00);
		send_frame(32'h0, 13'h0);
		put_word(32'd2);
		put_word(32'h1);
		send_frame(32'h1, 13'h0);
		put_word(32'd8);
		put_word(32'h4);
		put_word(32'd9);
		put_word(32'h4);
		frame.push_back(8'h00);
		send_frame(32'h4, 13'h1);
		put_word(32'd20);
		put_word(32'h6);
		repeat (3) frame.push_back(8'hA5);
		send_frame(32'h6, 13'h0);
		put_word(32'd8);
		put_word(32'hFFFF_FFFF);
		send_frame(32'hFFFF_FFFF, 13'h0);
		put_word(32'd8);
		put_word(32'h3);
		send_frame(32'h0, 13'h1FFF);
		drain();

		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_mask(32'h0);
				1: write_mask(32'hFFFF_FFFF);
				2: write_mask($urandom);
				3: write_mask(32'h1 << $urandom_range(0, 31));
				4: write_mask(tsf_pkg::FLAG_MASK_RESET);
				default: write_mask($urandom);
			endcase
			if (ph == 0) begin
				// flag bit no longer stripped
				put_word(32'd8);
				put_word(32'h2000_0001);
				send_frame(32'h1, 13'h0);
			end
			start = bytes_sent;
			while (bytes_sent - start < PHASE_BYTES)
				random_frame();
			drain();
		end

		$display("covered %0d payloads of %0d bytes under %0d mask settings",
			payloads, bytes_sent, mask_settings);
		$display("checked %0d found and %0d not-found results", found_seen, missing_seen);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire
